### design/erp_pkg.sv
package erp_pkg;

    localparam int unsigned MAX_STEPS = 16;
    localparam int unsigned STEP_W    = 5;
    localparam int unsigned PAT_W     = 16;
    localparam int unsigned ADDR_W    = $clog2(MAX_STEPS);

    typedef logic [STEP_W-1:0] step_t;
    typedef logic [PAT_W-1:0]  pat_t;
    typedef logic [ADDR_W-1:0] addr_t;

endpackage

### design/erp_req_if.sv
interface erp_req_if;
    import erp_pkg::*;

    logic  valid;
    logic  ready;
    step_t step_count;
    step_t hit_count;

    modport source (output valid, output step_count, output hit_count, input ready);
    modport sink   (input valid, input step_count, input hit_count, output ready);
endinterface

### design/erp_rsp_if.sv
interface erp_rsp_if;
    import erp_pkg::*;

    logic valid;
    logic ready;
    pat_t pattern;
    logic bad_request;

    modport source (output valid, output pattern, output bad_request, input ready);
    modport sink   (input valid, input pattern, input bad_request, output ready);
endinterface

### design/erp_join.sv
module erp_join (
    input  erp_pkg::pat_t head,
    input  erp_pkg::pat_t tail,
    output erp_pkg::pat_t joined
);
    import erp_pkg::*;

    logic [STEP_W-1:0]  len;
    logic [2*PAT_W-1:0] shifted;

    always_comb
    begin
        len = STEP_W'(1);
        for (int i = 0; i < PAT_W; i++)
        begin
            if (tail[i])
            begin
                len = STEP_W'(i + 1);
            end
        end
    end

    assign shifted = {{PAT_W{1'b0}}, head} << len;
    assign joined  = shifted[PAT_W-1:0] | tail;

endmodule

### design/euclidean_rhythm_pattern.sv
// Channel | Dir | Payload                        | Transaction
// req     | in  | step_count[4:0], hit_count[4:0] | valid & ready
// rsp     | out | pattern[15:0], bad_request      | valid & ready
//
// One request at a time; req.ready is high only while the sequencer is idle.
// Per request: the table fill writes an entry for each step, the divide finds
// pauses/hits by repeated subtraction, and each group join and each output
// group goes through the one join unit in a read state and a write state.
// Bad requests and zero hits skip the table fill and go straight to done.
// rst_n clears all control state; the group table needs no clearing.
// A result held on a stalled rsp still lets the next request start.
module euclidean_rhythm_pattern (
    input  logic         clk,
    input  logic         rst_n,
    erp_req_if.sink      req,
    erp_rsp_if.source    rsp
);
    import erp_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_INIT    = 11'b000_0000_0010,
        S_DIV     = 11'b000_0000_0100,
        S_SC_RD   = 11'b000_0000_1000,
        S_SC_WR   = 11'b000_0001_0000,
        S_LP_TEST = 11'b000_0010_0000,
        S_LP_RD   = 11'b000_0100_0000,
        S_LP_WR   = 11'b000_1000_0000,
        S_OUT_RD  = 11'b001_0000_0000,
        S_OUT_WR  = 11'b010_0000_0000,
        S_DONE    = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    step_t  n_reg, n_next;
    step_t  k_reg, k_next;
    step_t  cnt_reg, cnt_next;
    step_t  a_reg, a_next;
    step_t  b_reg, b_next;
    step_t  ga_reg, ga_next;
    step_t  gb_reg, gb_next;
    step_t  per_reg, per_next;
    step_t  rem_reg, rem_next;
    pat_t   acc_reg, acc_next;
    logic   bad_reg, bad_next;

    logic   rsp_valid_reg, rsp_valid_next;
    pat_t   pat_out_reg;
    logic   bad_out_reg;
    logic   load_out;

    pat_t   grp_mem [MAX_STEPS];
    logic   mem_we;
    addr_t  mem_waddr;
    pat_t   mem_wdata;
    logic   mem_re;
    addr_t  raddr_x;
    addr_t  raddr_y;
    pat_t   rd_x_reg;
    pat_t   rd_y_reg;

    step_t  n_sat;
    step_t  lim;
    step_t  tail_sc;
    step_t  tail_lp;
    pat_t   join_head;
    pat_t   join_tail;
    pat_t   join_out;

    assign n_sat   = (req.step_count > STEP_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS)
                                                           : req.step_count;
    assign lim     = (ga_reg > gb_reg) ? gb_reg : ga_reg;
    assign tail_sc = cnt_reg - STEP_W'(1) - b_reg;
    assign tail_lp = cnt_reg - STEP_W'(1) - a_reg;

    assign join_head = (state_reg == S_OUT_WR) ? acc_reg  : rd_x_reg;
    assign join_tail = (state_reg == S_OUT_WR) ? rd_x_reg : rd_y_reg;

    erp_join u_join (
        .head   (join_head),
        .tail   (join_tail),
        .joined (join_out)
    );

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.pattern     = pat_out_reg;
    assign rsp.bad_request = bad_out_reg;
    assign load_out        = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        ga_next    = ga_reg;
        gb_next    = gb_reg;
        per_next   = per_reg;
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        bad_next   = bad_reg;
        mem_we     = 1'b0;
        mem_waddr  = a_reg[ADDR_W-1:0];
        mem_wdata  = join_out;
        mem_re     = 1'b0;
        raddr_x    = a_reg[ADDR_W-1:0];
        raddr_y    = tail_lp[ADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    n_next   = n_sat;
                    k_next   = req.hit_count;
                    acc_next = '0;
                    a_next   = '0;
                    if (req.hit_count > n_sat)
                    begin
                        bad_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else if (req.hit_count == '0)
                    begin
                        bad_next   = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        bad_next   = 1'b0;
                        state_next = S_INIT;
                    end
                end
            end

            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = (a_reg < k_reg) ? PAT_W'(1) : '0;
                a_next    = a_reg + STEP_W'(1);
                if (a_reg == n_reg - STEP_W'(1))
                begin
                    rem_next   = n_reg - k_reg;
                    per_next   = '0;
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                if (rem_reg >= k_reg)
                begin
                    rem_next = rem_reg - k_reg;
                    per_next = per_reg + STEP_W'(1);
                end
                else
                begin
                    a_next   = '0;
                    b_next   = '0;
                    cnt_next = n_reg;
                    ga_next  = k_reg;
                    gb_next  = n_reg - k_reg;
                    if ((per_reg != '0) && (rem_reg < STEP_W'(2)))
                    begin
                        state_next = S_SC_RD;
                    end
                    else
                    begin
                        state_next = S_LP_TEST;
                    end
                end
            end

            S_SC_RD:
            begin
                if (a_reg == k_reg)
                begin
                    a_next     = '0;
                    acc_next   = '0;
                    state_next = S_OUT_RD;
                end
                else
                begin
                    mem_re     = 1'b1;
                    raddr_y    = tail_sc[ADDR_W-1:0];
                    state_next = S_SC_WR;
                end
            end

            S_SC_WR:
            begin
                mem_we = 1'b1;
                if (b_reg == per_reg - STEP_W'(1))
                begin
                    b_next   = '0;
                    a_next   = a_reg + STEP_W'(1);
                    cnt_next = cnt_reg - per_reg;
                end
                else
                begin
                    b_next = b_reg + STEP_W'(1);
                end
                state_next = S_SC_RD;
            end

            S_LP_TEST:
            begin
                a_next = '0;
                if (gb_reg > STEP_W'(1))
                begin
                    state_next = S_LP_RD;
                end
                else
                begin
                    acc_next   = '0;
                    state_next = S_OUT_RD;
                end
            end

            S_LP_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_LP_WR;
            end

            S_LP_WR:
            begin
                mem_we = 1'b1;
                if (a_reg == lim - STEP_W'(1))
                begin
                    cnt_next = cnt_reg - lim;
                    if (ga_reg > gb_reg)
                    begin
                        ga_next = gb_reg;
                        gb_next = ga_reg - gb_reg;
                    end
                    else if (gb_reg > ga_reg)
                    begin
                        gb_next = gb_reg - ga_reg;
                    end
                    else
                    begin
                        gb_next = '0;
                    end
                    state_next = S_LP_TEST;
                end
                else
                begin
                    a_next     = a_reg + STEP_W'(1);
                    state_next = S_LP_RD;
                end
            end

            S_OUT_RD:
            begin
                if (a_reg == cnt_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_OUT_WR;
                end
            end

            S_OUT_WR:
            begin
                acc_next   = join_out;
                a_next     = a_reg + STEP_W'(1);
                state_next = S_OUT_RD;
            end

            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (load_out)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            n_reg         <= '0;
            k_reg         <= '0;
            cnt_reg       <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            ga_reg        <= '0;
            gb_reg        <= '0;
            per_reg       <= '0;
            rem_reg       <= '0;
            bad_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            cnt_reg       <= cnt_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            ga_reg        <= ga_next;
            gb_reg        <= gb_next;
            per_reg       <= per_next;
            rem_reg       <= rem_next;
            bad_reg       <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (load_out)
        begin
            pat_out_reg <= acc_reg;
            bad_out_reg <= bad_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grp_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_x_reg <= grp_mem[raddr_x];
            rd_y_reg <= grp_mem[raddr_y];
        end
    end

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.bad_request |-> rsp.pattern == '0)
        else $error("bad request with nonzero pattern");

    a_bad_fast: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && (req.hit_count > n_sat) |=> state_reg == S_DONE)
        else $error("bad request did not finish at once");

    a_group_sum: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LP_RD |->
            ({1'b0, ga_reg} + {1'b0, gb_reg}) == {1'b0, cnt_reg})
        else $error("group counts lost track of table size");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT_RD |-> cnt_reg <= STEP_W'(MAX_STEPS))
        else $error("group count exceeds table");

endmodule
